@@ sv/two_operand_alu_flags_and_branch_core_macros.svh @@
// Assertion macros for the ALU, flags and branch core checker.
`ifndef TWO_OPERAND_ALU_FLAGS_AND_BRANCH_CORE_MACROS_SVH
`define TWO_OPERAND_ALU_FLAGS_AND_BRANCH_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define ALUF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aluf check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define ALUF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aluf check failed");

`endif

@@ sv/aluf_pkg.sv @@
// Shared types and constants of the ALU, flags and branch core.
package aluf_pkg;

   localparam logic [3:0] OP_MOV = 4'd0;
   localparam logic [3:0] OP_ADD = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_CMP = 4'd3;
   localparam logic [3:0] OP_BIC = 4'd4;
   localparam logic [3:0] OP_BIS = 4'd5;
   localparam logic [3:0] OP_AND = 4'd6;
   localparam logic [3:0] OP_XOR = 4'd7;
   localparam logic [3:0] OP_BIT = 4'd8;

   localparam logic [2:0] COND_JNE = 3'd0;
   localparam logic [2:0] COND_JEQ = 3'd1;
   localparam logic [2:0] COND_JNC = 3'd2;
   localparam logic [2:0] COND_JC  = 3'd3;
   localparam logic [2:0] COND_JN  = 3'd4;
   localparam logic [2:0] COND_JGE = 3'd5;
   localparam logic [2:0] COND_JL  = 3'd6;
   localparam logic [2:0] COND_JMP = 3'd7;

   localparam logic [1:0] KIND_REG   = 2'd0;
   localparam logic [1:0] KIND_CONST = 2'd1;
   localparam logic [1:0] KIND_IMM   = 2'd2;

   localparam int FLAG_C_BIT = 0;
   localparam int FLAG_Z_BIT = 1;
   localparam int FLAG_N_BIT = 2;
   localparam int FLAG_V_BIT = 8;

   localparam logic [15:0] WORD_MASK = 16'hFFFF;
   localparam logic [15:0] BYTE_MASK = 16'h00FF;
   localparam logic [19:0] PC16_MASK = 20'h0FFFF;
   localparam logic [19:0] PC20_MASK = 20'hFFFFF;

   localparam logic [1:0] COST_ONE = 2'd1;
   localparam logic [1:0] COST_TWO = 2'd2;

   localparam logic [2:0] REG_EXT_ADDR = 3'd0;

   typedef struct packed {
      logic        jump;
      logic        byte_size;
      logic [3:0]  op;
      logic [15:0] src;
      logic [15:0] dst;
      logic [15:0] addend;
      logic        cin;
      logic [15:0] status;
      logic [19:0] pc;
      logic        taken;
      logic [1:0]  cost;
   } s1_type;

   typedef struct packed {
      logic [15:0] result;
      logic        wb;
      logic        flags_upd;
      logic        carry;
      logic        ovf;
      logic        byte_size;
      logic [15:0] status;
      logic [19:0] pc;
      logic        taken;
      logic [1:0]  cost;
   } s2_type;

endpackage

@@ sv/aluf_exec.sv @@
// Execute stage logic: adder, logic unit, carry and overflow.
module aluf_exec (
   input  aluf_pkg::s1_type s1,
   output aluf_pkg::s2_type s2
);

   logic [15:0] mask;
   logic [16:0] sum;
   logic [15:0] sum_res;
   logic        b_msb;
   logic        d_msb;
   logic        s_msb;
   logic        r_msb;
   logic        a_carry;
   logic        a_ovf;
   logic [15:0] and_res;
   logic [15:0] xor_res;

   always_comb begin
      mask    = s1.byte_size ? aluf_pkg::BYTE_MASK : aluf_pkg::WORD_MASK;
      sum     = {1'b0, s1.dst} + {1'b0, s1.addend} + {16'd0, s1.cin};
      sum_res = sum[15:0] & mask;
      b_msb   = s1.byte_size ? s1.addend[7] : s1.addend[15];
      d_msb   = s1.byte_size ? s1.dst[7] : s1.dst[15];
      s_msb   = s1.byte_size ? s1.src[7] : s1.src[15];
      r_msb   = s1.byte_size ? sum[7] : sum[15];
      a_carry = s1.byte_size ? (|sum[16:8]) : sum[16];
      a_ovf   = (b_msb == d_msb) && (b_msb != r_msb);
      and_res = s1.dst & s1.src & mask;
      xor_res = (s1.dst ^ s1.src) & mask;
   end

   always_comb begin
      s2.result    = 16'd0;
      s2.wb        = 1'b0;
      s2.flags_upd = 1'b0;
      s2.carry     = 1'b0;
      s2.ovf       = 1'b0;
      s2.byte_size = s1.byte_size;
      s2.status    = s1.status;
      s2.pc        = s1.pc;
      s2.taken     = s1.taken;
      s2.cost      = s1.cost;
      if (!s1.jump) begin
         case (s1.op)
            aluf_pkg::OP_MOV: begin
               s2.result = s1.src & mask;
               s2.wb     = 1'b1;
            end
            aluf_pkg::OP_ADD, aluf_pkg::OP_SUB, aluf_pkg::OP_CMP: begin
               s2.result    = sum_res;
               s2.wb        = (s1.op != aluf_pkg::OP_CMP);
               s2.flags_upd = 1'b1;
               s2.carry     = a_carry;
               s2.ovf       = a_ovf;
            end
            aluf_pkg::OP_BIC: begin
               s2.result = s1.dst & ~s1.src & mask;
               s2.wb     = 1'b1;
            end
            aluf_pkg::OP_BIS: begin
               s2.result = (s1.dst | s1.src) & mask;
               s2.wb     = 1'b1;
            end
            aluf_pkg::OP_AND, aluf_pkg::OP_BIT: begin
               s2.result    = and_res;
               s2.wb        = (s1.op == aluf_pkg::OP_AND);
               s2.flags_upd = 1'b1;
               s2.carry     = (and_res != 16'd0);
            end
            aluf_pkg::OP_XOR: begin
               s2.result    = xor_res;
               s2.wb        = 1'b1;
               s2.flags_upd = 1'b1;
               s2.carry     = (xor_res != 16'd0);
               s2.ovf       = s_msb && d_msb;
            end
            default: begin
               s2.result = 16'd0;
            end
         endcase
      end
   end

endmodule

@@ sv/two_operand_alu_flags_and_branch_core.sv @@
// Top level: three-stage ALU with status flags and relative conditional jump.
// An accepted request passes through the stage 1, stage 2 and stage 3 registers to the rsp_ ports.
// Throughput: one request per cycle; each stage holds only while the next one is full
// and stalled, so bubbles close up.
// Reset: synchronous, active high; empties all stages and clears extended_addressing.
module two_operand_alu_flags_and_branch_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [3:0]         req_operation,
   input  logic               req_byte_size,
   input  logic [1:0]         req_source_kind,
   input  logic [15:0]        req_source_value,
   input  logic [15:0]        req_dest_value,
   input  logic [15:0]        req_status_in,
   input  logic [19:0]        req_next_pc,
   input  logic signed [10:0] req_jump_offset,
   input  logic [2:0]         req_jump_condition,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_result,
   output logic               rsp_dest_write,
   output logic [15:0]        rsp_status_out,
   output logic [19:0]        rsp_pc_out,
   output logic               rsp_jump_taken,
   output logic [1:0]         rsp_cycle_cost,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic REG_EXT_ADDR_BIT = aluf_pkg::REG_EXT_ADDR[2];

   logic ext_ff, ext_in;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic en1, en2, en3;

   aluf_pkg::s1_type s1_ff, s1_in;
   aluf_pkg::s2_type s2_ff, s2_in;

   logic [15:0] res_ff, res_in;
   logic        wb_ff, wb_in;
   logic [15:0] st_ff, st_in;
   logic [19:0] pc_ff, pc_in;
   logic        tk_ff, tk_in;
   logic [1:0]  cost_ff, cost_in;

   logic [15:0] mask;
   logic [15:0] src;
   logic        is_sub;
   logic [19:0] target;
   logic        flag_c, flag_z, flag_n, flag_v;
   logic        taken;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_EXT_ADDR_BIT) ? {31'd0, ext_ff} : 32'd0;

   always_comb begin
      ext_in = ext_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && (csr_paddr[2] == REG_EXT_ADDR_BIT)) begin
         ext_in = csr_pwdata[0];
      end
   end

   // stage enables: advance when empty or when the next stage advances
   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   // stage 1: operand preparation and jump resolution
   always_comb begin
      mask   = req_byte_size ? aluf_pkg::BYTE_MASK : aluf_pkg::WORD_MASK;
      if (req_source_kind == aluf_pkg::KIND_CONST) begin
         src = (req_byte_size && (req_source_value == aluf_pkg::WORD_MASK))
               ? aluf_pkg::BYTE_MASK : req_source_value;
      end else begin
         src = req_source_value & mask;
      end
      is_sub = (req_operation == aluf_pkg::OP_SUB) || (req_operation == aluf_pkg::OP_CMP);
      target = (req_next_pc + {{9{req_jump_offset[10]}}, req_jump_offset})
               & (ext_ff ? aluf_pkg::PC20_MASK : aluf_pkg::PC16_MASK);
      flag_c = req_status_in[aluf_pkg::FLAG_C_BIT];
      flag_z = req_status_in[aluf_pkg::FLAG_Z_BIT];
      flag_n = req_status_in[aluf_pkg::FLAG_N_BIT];
      flag_v = req_status_in[aluf_pkg::FLAG_V_BIT];
      case (req_jump_condition)
         aluf_pkg::COND_JNE: taken = !flag_z;
         aluf_pkg::COND_JEQ: taken = flag_z;
         aluf_pkg::COND_JNC: taken = !flag_c;
         aluf_pkg::COND_JC:  taken = flag_c;
         aluf_pkg::COND_JN:  taken = flag_n;
         aluf_pkg::COND_JGE: taken = (flag_n == flag_v);
         aluf_pkg::COND_JL:  taken = (flag_n != flag_v);
         default:            taken = 1'b1;
      endcase

      s1_in.jump      = req_mode;
      s1_in.byte_size = req_byte_size;
      s1_in.op        = req_operation;
      s1_in.src       = src;
      s1_in.dst       = req_dest_value & mask;
      s1_in.addend    = is_sub ? ~src : src;
      s1_in.cin       = is_sub;
      s1_in.status    = req_status_in;
      s1_in.pc        = (req_mode && taken) ? target : req_next_pc;
      s1_in.taken     = req_mode && taken;
      if (req_mode || (req_source_kind == aluf_pkg::KIND_IMM)) begin
         s1_in.cost = aluf_pkg::COST_TWO;
      end else begin
         s1_in.cost = aluf_pkg::COST_ONE;
      end
   end

   // stage 2: execute
   aluf_exec u_exec (
      .s1 (s1_ff),
      .s2 (s2_in)
   );

   // stage 3: zero and negative, status assembly
   always_comb begin
      res_in  = s2_ff.result;
      wb_in   = s2_ff.wb;
      pc_in   = s2_ff.pc;
      tk_in   = s2_ff.taken;
      cost_in = s2_ff.cost;
      st_in   = s2_ff.status;
      if (s2_ff.flags_upd) begin
         st_in[aluf_pkg::FLAG_C_BIT] = s2_ff.carry;
         st_in[aluf_pkg::FLAG_V_BIT] = s2_ff.ovf;
         st_in[aluf_pkg::FLAG_Z_BIT] = (s2_ff.result == 16'd0);
         st_in[aluf_pkg::FLAG_N_BIT] = s2_ff.byte_size ? s2_ff.result[7]
                                                       : s2_ff.result[15];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         ext_ff <= ext_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         res_ff  <= res_in;
         wb_ff   <= wb_in;
         st_ff   <= st_in;
         pc_ff   <= pc_in;
         tk_ff   <= tk_in;
         cost_ff <= cost_in;
      end
   end

   assign rsp_valid      = v3_ff;
   assign rsp_result     = res_ff;
   assign rsp_dest_write = wb_ff;
   assign rsp_status_out = st_ff;
   assign rsp_pc_out     = pc_ff;
   assign rsp_jump_taken = tk_ff;
   assign rsp_cycle_cost = cost_ff;

endmodule

@@ sv/aluf_checker.sv @@
// Port-level checker for the ALU, flags and branch core, with its bind.
`include "two_operand_alu_flags_and_branch_core_macros.svh"

module aluf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_result,
   input logic        rsp_dest_write,
   input logic [15:0] rsp_status_out,
   input logic [19:0] rsp_pc_out,
   input logic        rsp_jump_taken,
   input logic [1:0]  rsp_cycle_cost
);

   logic        jump_shape_ok;
   logic [55:0] payload;

   assign jump_shape_ok = (rsp_result == 16'd0) && !rsp_dest_write
                          && (rsp_cycle_cost == aluf_pkg::COST_TWO);
   assign payload = {rsp_result, rsp_dest_write, rsp_status_out, rsp_pc_out,
                     rsp_jump_taken, rsp_cycle_cost};

   `ALUF_ASSERT_NOW(a_empty_after_reset, $past(reset), !rsp_valid)
   `ALUF_ASSERT_NOW(a_jump_shape, rsp_valid && rsp_jump_taken, jump_shape_ok)
   `ALUF_ASSERT_NEXT(a_valid_hold, rsp_valid && rsp_stall, rsp_valid)
   `ALUF_ASSERT_NEXT(a_payload_hold, rsp_valid && rsp_stall, $stable(payload))

endmodule

bind two_operand_alu_flags_and_branch_core aluf_checker u_aluf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_result     (rsp_result),
   .rsp_dest_write (rsp_dest_write),
   .rsp_status_out (rsp_status_out),
   .rsp_pc_out     (rsp_pc_out),
   .rsp_jump_taken (rsp_jump_taken),
   .rsp_cycle_cost (rsp_cycle_cost)
);
